// File: src/mdc_pkg.sv
// ----------------------------------------------------------------------------
// mdc_pkg: shared types and a helper for the motor drive compensation block
// Request and response payloads, the configuration register map, the shaped
// per-motor configuration and the layout of one state memory word.
// ----------------------------------------------------------------------------
package mdc_pkg;

	localparam int NUM_MOTORS = 2;
	localparam int MOTOR_W    = 1;
	localparam int Q_W        = 24;
	localparam int EPS_W      = 23;
	localparam int GAIN_W     = 16;
	localparam int BTIME_W    = 16;
	localparam int TIME_W     = 32;
	localparam int CFG_DATA_W = 48;
	localparam int CFG_IDX_W  = 3;
	localparam int FRAC_SHIFT = 12;
	localparam int PROD_W     = Q_W + GAIN_W + 1;
	localparam int SHIFTED_W  = PROD_W - FRAC_SHIFT;

	localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(4096);
	localparam logic [Q_W-1:0]    Q_MAX    = 24'h7FFFFF;
	localparam logic [Q_W-1:0]    Q_MIN    = 24'h800000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEADBAND   = 3'd0,
		REG_LIMIT      = 3'd1,
		REG_GAIN       = 3'd2,
		REG_MIN_DRIVE  = 3'd3,
		REG_BOOST      = 3'd4,
		REG_BOOST_TIME = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [MOTOR_W-1:0] motor_sel;
		logic [Q_W-1:0]     speed_cmd;
		logic [Q_W-1:0]     measured_speed;
		logic [Q_W-1:0]     pid_drive;
		logic [TIME_W-1:0]  now_ms;
	} req_t;

	typedef struct packed {
		logic [MOTOR_W-1:0] motor_id;
		logic [Q_W-1:0]     drive_out;
	} rsp_t;

	// Per-motor settings after clean-up: gain never zero, levels within limit.
	typedef struct packed {
		logic [GAIN_W-1:0]  gain;
		logic [Q_W-1:0]     min_drive;
		logic [Q_W-1:0]     boost_drive;
		logic [BTIME_W-1:0] boost_time;
	} motor_cfg_t;

	typedef struct packed {
		logic [EPS_W-1:0]                  deadband;
		logic [EPS_W-1:0]                  limit;
		motor_cfg_t [NUM_MOTORS-1:0]       motor;
	} cfg_t;

	typedef struct packed {
		logic [Q_W-1:0]    prev_target;
		logic [TIME_W-1:0] deadline;
	} state_t;

	// Magnitude of a Q16.8 value; the most negative code maps to 2^23.
	function automatic logic [Q_W-1:0] mag24(input logic [Q_W-1:0] v);
		mag24 = v[Q_W-1] ? Q_W'(-v) : v;
	endfunction

endpackage

// File: src/motor_drive_compensation.sv
// ----------------------------------------------------------------------------
// motor_drive_compensation: post-PID drive shaping for two motors
// Deadband, startup boost, minimum drive, gain scaling and symmetric clamp,
// with the per-motor state kept in a small read-modify-write memory.
// ----------------------------------------------------------------------------
// Order: the state is read at acceptance, then the gain multiply runs with
// the state write-back, then the shaping fills the output register.
// Throughput: one request per cycle while the output register is free or
// being drained, kept up by the state memory read-modify-write with
// forwarding between back-to-back requests.
// Reset: configuration returns to its defaults, the pipeline empties and the
// state entries read as zero through per-entry valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module motor_drive_compensation (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  mdc_pkg::req_t                   req,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output mdc_pkg::rsp_t                   rsp,
	input  logic                            cfg_we,
	input  logic [mdc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mdc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import mdc_pkg::*;

	// The whole pipeline moves together whenever the output register is free
	// or being drained. A request is taken only as it moves, and enters stage 1.
	logic   adv;
	logic   req_fire;
	cfg_t   cfg;

	// Stage 1: request fields plus the state word arriving from memory.
	logic               vld_s1;
	req_t               req_s1;
	logic               fwd_s1;
	state_t             fwd_data_s1;
	state_t             rd_data;
	state_t             cur_s1;
	motor_cfg_t         mc_s1;
	logic               motor_ok_s1;
	logic [Q_W-1:0]     tmag_s1;
	logic [Q_W-1:0]     pmag_s1;
	logic [Q_W-1:0]     smag_s1;
	logic               deadband_s1;
	logic               stopped_s1;
	logic               reversed_s1;
	logic               arm_s1;
	logic               lagging_s1;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [Q_W-1:0]    pid_s1;
	state_t             new_state_s1;
	logic               wr_en;

	// Stage 2: product and the decisions that the shaping needs.
	logic                     vld_s2;
	logic [MOTOR_W-1:0]       motor_s2;
	logic                     active_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic                     tneg_s2;
	logic                     lagging_s2;
	logic [TIME_W-1:0]        now_s2;
	logic [TIME_W-1:0]        deadline_s2;
	motor_cfg_t               mc_s2;
	logic signed [SHIFTED_W-1:0] shifted_s2;
	logic [Q_W-1:0]           sat_s2;
	logic                     same_dir_s2;
	logic                     window_s2;
	logic [Q_W-1:0]           boosted_s2;
	logic [Q_W-1:0]           raised_s2;
	logic [Q_W-1:0]           raised_mag_s2;
	logic [Q_W-1:0]           limit_ext;
	logic [Q_W-1:0]           drive_s2;

	// Output register.
	logic rsp_valid_q;
	rsp_t rsp_q;

	assign adv       = !rsp_valid_q || rsp_ready;
	assign req_ready = adv;
	assign req_fire  = req_valid && req_ready;

	mdc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// The state word is read at the address of the incoming request and
	// written back when that request leaves stage 1.
	mdc_state_mem u_state (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (req_fire),
		.rd_addr (req.motor_sel),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (req_s1.motor_sel),
		.wr_data (new_state_s1)
	);

	// ---------------------------------------------------------------- stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= req_valid;
			// The memory returns the old word when the request ahead writes
			// the same motor at this edge, so that write is forwarded.
			if (req_fire) begin
				fwd_s1 <= wr_en && (req_s1.motor_sel == req.motor_sel);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_s1      <= req;
			fwd_data_s1 <= new_state_s1;
		end
	end

	assign cur_s1 = fwd_s1 ? fwd_data_s1 : rd_data;
	assign mc_s1  = cfg.motor[req_s1.motor_sel];
	assign motor_ok_s1 = {1'b0, req_s1.motor_sel} < 2'(NUM_MOTORS);

	assign tmag_s1 = mag24(req_s1.speed_cmd);
	assign pmag_s1 = mag24(cur_s1.prev_target);
	assign smag_s1 = mag24(req_s1.measured_speed);

	assign deadband_s1 = tmag_s1 <= {1'b0, cfg.deadband};
	assign stopped_s1  = pmag_s1 <= {1'b0, cfg.deadband};
	assign reversed_s1 =
		(cur_s1.prev_target[Q_W-1] && !req_s1.speed_cmd[Q_W-1] &&
		 (req_s1.speed_cmd != '0)) ||
		(!cur_s1.prev_target[Q_W-1] && (cur_s1.prev_target != '0) &&
		 req_s1.speed_cmd[Q_W-1]);
	assign arm_s1 = (stopped_s1 || reversed_s1) && (mc_s1.boost_drive != '0) &&
		(mc_s1.boost_time != '0);

	// Exact lag test: |speed| + deadband < |target|, one bit of headroom.
	assign lagging_s1 = ({1'b0, smag_s1} + {2'b0, cfg.deadband}) < {1'b0, tmag_s1};

	// A target inside the deadband clears the motor's state; otherwise the
	// target is remembered and the deadline is re-armed when a start or a
	// reversal calls for a boost.
	always_comb begin
		if (deadband_s1) begin
			new_state_s1 = '0;
		end else begin
			new_state_s1.prev_target = req_s1.speed_cmd;
			new_state_s1.deadline    = arm_s1 ?
				req_s1.now_ms + {{(TIME_W-BTIME_W){1'b0}}, mc_s1.boost_time} :
				cur_s1.deadline;
		end
	end

	assign wr_en = vld_s1 && adv && motor_ok_s1;

	assign pid_s1  = req_s1.pid_drive;
	assign prod_s1 = pid_s1 * $signed({1'b0, mc_s1.gain});

	// ---------------------------------------------------------------- stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s1) begin
			motor_s2    <= req_s1.motor_sel;
			active_s2   <= motor_ok_s1 && !deadband_s1;
			prod_s2     <= prod_s1;
			tneg_s2     <= req_s1.speed_cmd[Q_W-1];
			lagging_s2  <= lagging_s1;
			now_s2      <= req_s1.now_ms;
			deadline_s2 <= new_state_s1.deadline;
		end
	end

	assign mc_s2     = cfg.motor[motor_s2];
	assign limit_ext = {1'b0, cfg.limit};

	// Drop the Q4.12 fraction (floor) and saturate to the Q16.8 range.
	assign shifted_s2 = SHIFTED_W'(prod_s2 >>> FRAC_SHIFT);
	always_comb begin
		if (shifted_s2[SHIFTED_W-1:Q_W-1] == {(SHIFTED_W-Q_W+1){shifted_s2[Q_W-1]}}) begin
			sat_s2 = shifted_s2[Q_W-1:0];
		end else begin
			sat_s2 = shifted_s2[SHIFTED_W-1] ? Q_MIN : Q_MAX;
		end
	end

	assign same_dir_s2 = (sat_s2 == '0) || (sat_s2[Q_W-1] == tneg_s2);
	assign window_s2   = now_s2 < deadline_s2;

	// Boost first, then the minimum level, both only while the wheel lags
	// and the drive already pushes toward the target.
	always_comb begin
		if ((mc_s2.boost_drive != '0) && window_s2 && same_dir_s2 && lagging_s2 &&
			(mag24(sat_s2) < mc_s2.boost_drive)) begin
			boosted_s2 = tneg_s2 ? Q_W'(-mc_s2.boost_drive) : mc_s2.boost_drive;
		end else begin
			boosted_s2 = sat_s2;
		end
		if ((mc_s2.min_drive != '0) && same_dir_s2 && lagging_s2 &&
			(mag24(boosted_s2) < mc_s2.min_drive)) begin
			raised_s2 = tneg_s2 ? Q_W'(-mc_s2.min_drive) : mc_s2.min_drive;
		end else begin
			raised_s2 = boosted_s2;
		end
	end

	// Symmetric clamp to the output limit; inactive requests give zero.
	assign raised_mag_s2 = mag24(raised_s2);
	always_comb begin
		if (!active_s2) begin
			drive_s2 = '0;
		end else if (raised_mag_s2 > limit_ext) begin
			drive_s2 = raised_s2[Q_W-1] ? Q_W'(-limit_ext) : limit_ext;
		end else begin
			drive_s2 = raised_s2;
		end
	end

	// ---------------------------------------------------------------- output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s2) begin
			rsp_q.motor_id  <= motor_s2;
			rsp_q.drive_out <= drive_s2;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// An accepted request occupies stage 1 in the next cycle.
	a_req_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> vld_s1)
		else $error("accepted request did not reach stage 1");

	// A write-back to the motor being read must be forwarded to the new request.
	a_fwd_taken: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && wr_en && (req_s1.motor_sel == req.motor_sel) |=> fwd_s1)
		else $error("state write-back not forwarded to following request");

	// A request leaving stage 1 is always in stage 2 on the next cycle.
	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && adv |=> vld_s2)
		else $error("request lost between stage 1 and stage 2");

endmodule

// File: src/mdc_cfg.sv
// ----------------------------------------------------------------------------
// mdc_cfg: configuration registers
// Holds the six programmable registers and derives the cleaned per-motor
// settings (unity gain for a zero code, drive levels capped at the limit).
// ----------------------------------------------------------------------------
module mdc_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mdc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mdc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output mdc_pkg::cfg_t                    cfg
);
	import mdc_pkg::*;

	logic [EPS_W-1:0]             deadband_q;
	logic [EPS_W-1:0]             limit_q;
	logic [NUM_MOTORS*GAIN_W-1:0] gain_q;
	logic [NUM_MOTORS*Q_W-1:0]    min_q;
	logic [NUM_MOTORS*Q_W-1:0]    boost_q;
	logic [NUM_MOTORS*BTIME_W-1:0] btime_q;
	logic [Q_W-1:0]               limit_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q <= EPS_W'(1280);
			limit_q    <= EPS_W'(8388607);
			gain_q     <= {NUM_MOTORS{GAIN_ONE}};
			min_q      <= '0;
			boost_q    <= '0;
			btime_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DEADBAND:   deadband_q <= cfg_wdata[EPS_W-1:0];
				REG_LIMIT:      limit_q    <= cfg_wdata[EPS_W-1:0];
				REG_GAIN:       gain_q     <= cfg_wdata[NUM_MOTORS*GAIN_W-1:0];
				REG_MIN_DRIVE:  min_q      <= cfg_wdata[NUM_MOTORS*Q_W-1:0];
				REG_BOOST:      boost_q    <= cfg_wdata[NUM_MOTORS*Q_W-1:0];
				REG_BOOST_TIME: btime_q    <= cfg_wdata[NUM_MOTORS*BTIME_W-1:0];
				default: ;
			endcase
		end
	end

	assign limit_ext = {1'b0, limit_q};

	always_comb begin
		cfg.deadband = deadband_q;
		cfg.limit    = limit_q;
		for (int i = 0; i < NUM_MOTORS; i++) begin
			cfg.motor[i].gain = (gain_q[i*GAIN_W +: GAIN_W] == '0) ?
				GAIN_ONE : gain_q[i*GAIN_W +: GAIN_W];
			cfg.motor[i].min_drive = (min_q[i*Q_W +: Q_W] > limit_ext) ?
				limit_ext : min_q[i*Q_W +: Q_W];
			cfg.motor[i].boost_drive = (boost_q[i*Q_W +: Q_W] > limit_ext) ?
				limit_ext : boost_q[i*Q_W +: Q_W];
			cfg.motor[i].boost_time = btime_q[i*BTIME_W +: BTIME_W];
		end
	end

endmodule

// File: src/mdc_state_mem.sv
// ----------------------------------------------------------------------------
// mdc_state_mem: per-motor state memory
// One word per motor, registered read data. Each entry has a valid bit that
// reset clears; an entry that was never written reads as zero.
// ----------------------------------------------------------------------------
module mdc_state_mem (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [mdc_pkg::MOTOR_W-1:0]   rd_addr,
	output mdc_pkg::state_t               rd_data,
	input  logic                          wr_en,
	input  logic [mdc_pkg::MOTOR_W-1:0]   wr_addr,
	input  mdc_pkg::state_t               wr_data
);
	import mdc_pkg::*;

	state_t                mem_q [NUM_MOTORS];
	logic [NUM_MOTORS-1:0] vld_q;
	state_t                rd_q;
	logic                  rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

	// Once an entry holds written data it stays valid until the next reset.
	a_vld_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q & $past(vld_q)) == $past(vld_q))
		else $error("state entry lost its valid bit");

endmodule

// File: verif/tb_motor_drive_compensation.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_motor_drive_compensation: self-checking bench for the drive shaping block
// A short table of hand-picked requests and register writes comes first. After
// it come randomized phases, each with its own register settings. Every
// response is checked against its typed drive or a behavioral model here.
// ----------------------------------------------------------------------------
module tb_motor_drive_compensation;

	import mdc_pkg::*;

	// Cycles with no accepted request or response before the run is abandoned.
	localparam int STALL_LIMIT   = 5000;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 150;
	localparam int LONG_HOLD     = 300;
	localparam int DIR_ROWS      = 33;

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

	// One line of the directed table. A register write uses kind, idx and data.
	// A request uses the request fields, and chk marks a typed expected drive.
	typedef struct packed {
		row_kind_t          kind;
		cfg_reg_t           idx;
		logic [47:0]        data;
		logic               motor;
		logic [23:0]        target;
		logic [23:0]        meas;
		logic [23:0]        pid;
		logic [31:0]        now;
		logic               chk;
		logic [23:0]        drive;
	} dir_row_t;

	// The first rows run with the reset settings: deadband 1280, a full-scale limit,
	// unity gain and no minimum or boost level. Later rows set up clamping,
	// extreme gains, a zero gain, the minimum level and the startup boost.
	localparam dir_row_t DIRECTED [0:DIR_ROWS-1] = '{
		// Targets inside the deadband give zero drive.
		'{ROW_REQ, REG_DEADBAND, 48'd0, 1'b0, 24'd0, 24'd0, 24'd1000, 32'd0, 1'b1, 24'd0},
		'{ROW_REQ, REG_DEADBAND, 48'd0, 1'b1, 24'd1280, 24'd0, -24'sd500, 32'd1, 1'b1, 24'd0},
		'{ROW_REQ, REG_DEADBAND, 48'd0, 1'b0, -24'sd1280, 24'd0, 24'd9, 32'd1, 1'b1, 24'd0},
		// Just outside the deadband, unity gain passes the PID value through.
		'{ROW_REQ, REG_DEADBAND, 48'd0, 1'b0, 24'd1281, 24'h7FFFFF, 24'd100, 32'd2,
			1'b1, 24'd100},
		// Field extremes; the most negative drive is clamped to minus the limit.
		'{ROW_REQ, REG_DEADBAND, 48'd0, 1'b1, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 32'd3,
			1'b1, 24'h7FFFFF},
		'{ROW_REQ, REG_DEADBAND, 48'd0, 1'b0, 24'h800000, 24'd0, 24'h800000, 32'hFFFFFFFF,
			1'b1, 24'h800001},
		// Largest gain on both motors: the product saturates.
		'{ROW_CFG, REG_GAIN, 48'hFFFF_FFFF_FFFF, 1'b0, 24'd0, 24'd0, 24'd0, 32'd0, 1'b0, 24'd0},
		'{ROW_REQ, REG_DEADBAND, 48'd0, 1'b1, 24'd5000, 24'd0, 24'h7FFFFF, 32'd4,
			1'b1, 24'h7FFFFF},
		'{ROW_REQ, REG_DEADBAND, 48'd0, 1'b0, -24'sd5000, 24'd0, 24'h800000, 32'd5,
			1'b1, 24'h800001},
		'{ROW_REQ, REG_DEADBAND, 48'd0, 1'b0, 24'd5000, 24'd0, -24'sd1, 32'd6, 1'b0, 24'd0},
		// A zero gain acts as unity; a small limit clamps both signs.
		'{ROW_CFG, REG_GAIN, 48'd0, 1'b0, 24'd0, 24'd0, 24'd0, 32'd0, 1'b0, 24'd0},
		'{ROW_CFG, REG_LIMIT, 48'd1000, 1'b0, 24'd0, 24'd0, 24'd0, 32'd0, 1'b0, 24'd0},
		'{ROW_REQ, REG_DEADBAND, 48'd0, 1'b1, 24'd5000, 24'd0, 24'd3000, 32'd7, 1'b1, 24'd1000},
		'{ROW_REQ, REG_DEADBAND, 48'd0, 1'b1, -24'sd5000, 24'd0, -24'sd3000, 32'd8,
			1'b1, 24'hFFFC18},
		'{ROW_CFG, REG_LIMIT, 48'h7FFFFF, 1'b0, 24'd0, 24'd0, 24'd0, 32'd0, 1'b0, 24'd0},
		// With no deadband the smallest nonzero target is live.
		'{ROW_CFG, REG_DEADBAND, 48'd0, 1'b0, 24'd0, 24'd0, 24'd0, 32'd0, 1'b0, 24'd0},
		'{ROW_REQ, REG_DEADBAND, 48'd0, 1'b0, 24'd1, 24'd0, 24'd7, 32'd9, 1'b1, 24'd7},
		// Minimum 2000 and 3000, boost 5000 and an over-limit boost, durations
		// of 100 ms and the longest one.
		'{ROW_CFG, REG_MIN_DRIVE, 48'h000BB8_0007D0, 1'b0, 24'd0, 24'd0, 24'd0, 32'd0,
			1'b0, 24'd0},
		'{ROW_CFG, REG_BOOST, 48'hFFFFFF_001388, 1'b0, 24'd0, 24'd0, 24'd0, 32'd0, 1'b0, 24'd0},
		'{ROW_CFG, REG_BOOST_TIME, 48'h0000_FFFF_0064, 1'b0, 24'd0, 24'd0, 24'd0, 32'd0,
			1'b0, 24'd0},
		'{ROW_CFG, REG_DEADBAND, 48'd1280, 1'b0, 24'd0, 24'd0, 24'd0, 32'd0, 1'b0, 24'd0},
		// Stop motor 0, then start it: boost until the deadline, then minimum.
		'{ROW_REQ, REG_DEADBAND, 48'd0, 1'b0, 24'd0, 24'd0, 24'd0, 32'd900, 1'b1, 24'd0},
		'{ROW_REQ, REG_DEADBAND, 48'd0, 1'b0, 24'd10000, 24'd0, 24'd10, 32'd1000, 1'b0, 24'd0},
		'{ROW_REQ, REG_DEADBAND, 48'd0, 1'b0, 24'd10000, 24'd0, 24'd10, 32'd1099, 1'b0, 24'd0},
		'{ROW_REQ, REG_DEADBAND, 48'd0, 1'b0, 24'd10000, 24'd0, 24'd10, 32'd1100, 1'b0, 24'd0},
		// Speed close enough to the target: no raise.
		'{ROW_REQ, REG_DEADBAND, 48'd0, 1'b0, 24'd10000, 24'd9000, 24'd10, 32'd1101,
			1'b0, 24'd0},
		// Reversal arms a new boost; a drive against the target is not raised.
		'{ROW_REQ, REG_DEADBAND, 48'd0, 1'b0, -24'sd10000, 24'd0, -24'sd10, 32'd1200,
			1'b0, 24'd0},
		'{ROW_REQ, REG_DEADBAND, 48'd0, 1'b0, -24'sd10000, 24'd0, 24'd50, 32'd1210, 1'b0, 24'd0},
		'{ROW_REQ, REG_DEADBAND, 48'd0, 1'b0, -24'sd10000, 24'd0, -24'sd6000, 32'd1220,
			1'b0, 24'd0},
		// Motor 1 reverses with a boost level above the limit.
		'{ROW_REQ, REG_DEADBAND, 48'd0, 1'b1, 24'd20000, 24'd0, 24'd0, 32'd1300, 1'b0, 24'd0},
		'{ROW_REQ, REG_DEADBAND, 48'd0, 1'b1, 24'd0, 24'd0, 24'd0, 32'd1301, 1'b1, 24'd0},
		// A deadline that wraps past zero never opens the window at arming time.
		'{ROW_REQ, REG_DEADBAND, 48'd0, 1'b0, 24'd10000, 24'd0, 24'd0, 32'hFFFFFFF0,
			1'b0, 24'd0},
		'{ROW_REQ, REG_DEADBAND, 48'd0, 1'b0, -24'sd10000, 24'd0, 24'd0, 32'h10, 1'b0, 24'd0}
	};

	logic  clk;
	logic  arst_n;
	logic  req_valid;
	logic  req_ready;
	req_t  req;
	logic  rsp_valid;
	logic  rsp_ready;
	rsp_t  rsp;
	logic  cfg_we;
	logic  [CFG_IDX_W-1:0]  cfg_index;
	logic  [CFG_DATA_W-1:0] cfg_wdata;

	motor_drive_compensation u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Copies of the configuration registers as the block should hold them.
	logic [22:0] set_deadband;
	logic [22:0] set_limit;
	logic [31:0] set_gain;
	logic [47:0] set_min;
	logic [47:0] set_boost;
	logic [31:0] set_boost_time;

	// Per-motor state of the behavioral model.
	longint      motor_prev_target [2];
	logic [31:0] motor_boost_end   [2];

	// Drive values still owed by the block, oldest first.
	rsp_t        pending_drive [$];

	int          error_count;
	int          long_hold;
	bit          send_idle_on;
	bit          recv_idle_on;

	// Stimulus shaping: running time stamp and the last target sign per motor.
	logic [31:0] cur_now;
	bit          last_neg [2];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint abs_q(input longint v);
		abs_q = (v < 0) ? -v : v;
	endfunction

	// Behavioral model of one request: deadband, boost arming, gain product,
	// boost and minimum raise, then the symmetric clamp. It updates the
	// motor state exactly as the block should.
	function automatic rsp_t predict_drive(input req_t r);
		rsp_t        res;
		int          m;
		longint      eps, lim, tgt, spd, pid, gain, min_d, boost_d, prod, drive, prev;
		logic [31:0] btime;
		bit          stopped, reversed, same_dir, lagging;
		m     = int'(r.motor_sel);
		eps   = longint'(set_deadband);
		lim   = longint'(set_limit);
		tgt   = longint'($signed(r.speed_cmd));
		spd   = longint'($signed(r.measured_speed));
		pid   = longint'($signed(r.pid_drive));
		drive = 0;
		res.motor_id = r.motor_sel;
		if (abs_q(tgt) <= eps) begin
			motor_prev_target[m] = 0;
			motor_boost_end[m]   = '0;
		end else begin
			gain    = longint'(m ? set_gain[31:16] : set_gain[15:0]);
			min_d   = longint'(m ? set_min[47:24] : set_min[23:0]);
			boost_d = longint'(m ? set_boost[47:24] : set_boost[23:0]);
			btime   = m ? {16'd0, set_boost_time[31:16]} : {16'd0, set_boost_time[15:0]};
			prev    = motor_prev_target[m];
			if (gain == 0)
				gain = 4096;
			if (min_d > lim)
				min_d = lim;
			if (boost_d > lim)
				boost_d = lim;
			stopped  = abs_q(prev) <= eps;
			reversed = (prev < 0 && tgt > 0) || (prev > 0 && tgt < 0);
			if ((stopped || reversed) && boost_d > 0 && btime != 0)
				motor_boost_end[m] = r.now_ms + btime;
			// An arithmetic shift of the exact product rounds toward minus infinity.
			prod  = pid * gain;
			drive = prod >>> FRAC_SHIFT;
			if (drive > 8388607)
				drive = 8388607;
			if (drive < -8388608)
				drive = -8388608;
			same_dir = (drive == 0) || ((drive < 0) == (tgt < 0));
			lagging  = abs_q(spd) + eps < abs_q(tgt);
			if (boost_d > 0 && r.now_ms < motor_boost_end[m] && same_dir && lagging &&
				abs_q(drive) < boost_d)
				drive = (tgt >= 0) ? boost_d : -boost_d;
			if (min_d > 0 && same_dir && lagging && abs_q(drive) < min_d)
				drive = (tgt >= 0) ? min_d : -min_d;
			motor_prev_target[m] = tgt;
		end
		if (drive > lim)
			drive = lim;
		if (drive < -lim)
			drive = -lim;
		res.drive_out = drive[23:0];
		return res;
	endfunction

	// Writes one register at the next edge and mirrors it, masked to the
	// register's width, into the model's copy. Called only while idle.
	task automatic load_reg(input cfg_reg_t idx, input logic [47:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			REG_DEADBAND:   set_deadband   = data[22:0];
			REG_LIMIT:      set_limit      = data[22:0];
			REG_GAIN:       set_gain       = data[31:0];
			REG_MIN_DRIVE:  set_min        = data;
			REG_BOOST:      set_boost      = data;
			REG_BOOST_TIME: set_boost_time = data[31:0];
			default: ;
		endcase
		// The enable is lowered before the task waits again, so back-to-back writes
		// never assign it twice in one time step.
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Stops offering requests until every owed response has been taken.
	task automatic drain_requests();
		req_valid <= 1'b0;
		while (pending_drive.size() != 0)
			@(posedge clk);
	endtask

	// Offers one request, after a random gap when idling is on, and waits for
	// it to be accepted. At acceptance the model runs, and either its result
	// or the typed drive from the table is queued as the expectation.
	task automatic send_req(input req_t r, input bit typed, input logic [23:0] typed_drive);
		int   gap;
		rsp_t want;
		gap = send_idle_on ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do
			@(posedge clk);
		while (!req_ready);
		want = predict_drive(r);
		if (typed)
			want.drive_out = typed_drive;
		pending_drive.push_back(want);
	endtask

	// Picks a 24-bit level: mostly a useful magnitude, sometimes zero or all ones.
	function automatic logic [23:0] pick_level(input int unsigned span);
		case ($urandom_range(0, 7))
			0: pick_level = '0;
			1: pick_level = '1;
			default: pick_level = 24'($urandom_range(0, span));
		endcase
	endfunction

	function automatic logic [15:0] pick_gain();
		case ($urandom_range(0, 5))
			0: pick_gain = 16'h0000;
			1: pick_gain = 16'h1000;
			2: pick_gain = 16'hFFFF;
			3: pick_gain = 16'($urandom);
			default: pick_gain = 16'($urandom_range(2048, 8192));
		endcase
	endfunction

	function automatic logic [15:0] pick_duration();
		case ($urandom_range(0, 5))
			0: pick_duration = 16'h0000;
			1: pick_duration = 16'hFFFF;
			default: pick_duration = 16'($urandom_range(1, 150));
		endcase
	endfunction

	// New settings for a phase. Phase 1 zeroes the deadband and takes the rest to
	// the top, phase 2 takes all to the bottom (with the widest deadband); other
	// phases mix. Bits above a register's width carry noise the block must ignore.
	task automatic load_phase_settings(input int phase);
		logic [47:0] noise;
		logic [47:0] eps_v, lim_v, gain_v, min_v, boost_v, btime_v;
		noise = {16'($urandom), 32'($urandom)};
		if (phase == 1) begin
			eps_v   = 48'd0;
			lim_v   = 48'h7FFFFF;
			gain_v  = 48'hFFFFFFFF;
			min_v   = '1;
			boost_v = '1;
			btime_v = 48'hFFFFFFFF;
		end else if (phase == 2) begin
			eps_v   = 48'h7FFFFF;
			lim_v   = 48'd0;
			gain_v  = 48'd0;
			min_v   = 48'd0;
			boost_v = 48'd0;
			btime_v = 48'd0;
		end else begin
			eps_v   = ($urandom_range(0, 7) == 0) ? 48'd0 : 48'($urandom_range(0, 3000));
			case ($urandom_range(0, 3))
				0: lim_v = 48'h7FFFFF;
				1: lim_v = 48'($urandom_range(0, 8388607));
				default: lim_v = 48'($urandom_range(1000, 50000));
			endcase
			gain_v  = {16'd0, pick_gain(), pick_gain()};
			min_v   = {pick_level(20000), pick_level(20000)};
			boost_v = {pick_level(40000), pick_level(40000)};
			btime_v = {16'd0, pick_duration(), pick_duration()};
		end
		load_reg(REG_DEADBAND,   {noise[47:23], eps_v[22:0]});
		load_reg(REG_LIMIT,      {noise[47:23], lim_v[22:0]});
		load_reg(REG_GAIN,       {noise[47:32], gain_v[31:0]});
		load_reg(REG_MIN_DRIVE,  min_v);
		load_reg(REG_BOOST,      boost_v);
		load_reg(REG_BOOST_TIME, {noise[47:32], btime_v[31:0]});
	endtask

	// Clips a wide value into the 24-bit signed field.
	function automatic logic [23:0] to_q(input longint v);
		if (v > 8388607)
			v = 8388607;
		if (v < -8388608)
			v = -8388608;
		to_q = v[23:0];
	endfunction

	// Builds one random request. Most are plausible control samples: a target
	// that keeps its sign for a while, a speed that lags behind it and a PID
	// output near the minimum and boost levels, with time moving forward in
	// small steps so that boost windows open and close. About one in ten is
	// pure noise across every bit of every field.
	function automatic req_t next_sample();
		req_t        r;
		int          m;
		longint      span, tmag, tgt, smag;
		cur_now = cur_now + 32'($urandom_range(0, 30));
		if ($urandom_range(0, 39) == 0)
			cur_now = $urandom;
		if ($urandom_range(0, 9) == 0) begin
			r.motor_sel      = 1'($urandom);
			r.speed_cmd      = 24'($urandom);
			r.measured_speed = 24'($urandom);
			r.pid_drive      = 24'($urandom);
			r.now_ms         = $urandom;
			return r;
		end
		m    = $urandom_range(0, 1);
		span = longint'(set_deadband) * 4 + 40000;
		if (span > 8388607)
			span = 8388607;
		case ($urandom_range(0, 15))
			0: tmag = 0;
			1: tmag = longint'(set_deadband);
			2: tmag = longint'(set_deadband) + 1;
			3: tmag = 8388608;
			4: tmag = longint'($urandom_range(0, 8388607));
			default: tmag = longint'($urandom_range(0, int'(span)));
		endcase
		if ($urandom_range(0, 4) == 0)
			last_neg[m] = !last_neg[m];
		tgt = last_neg[m] ? -tmag : tmag;
		r.motor_sel    = 1'(m);
		r.speed_cmd    = to_q(tgt);
		r.now_ms       = cur_now;
		case ($urandom_range(0, 4))
			0: r.measured_speed = 24'($urandom);
			1: begin
				smag = tmag + longint'($urandom_range(0, 3000)) - 1500;
				r.measured_speed = to_q(last_neg[m] ? -smag : smag);
			end
			default: begin
				smag = longint'($urandom_range(0, int'(tmag > 8388607 ? 8388607 : tmag)));
				r.measured_speed = to_q(last_neg[m] ? -smag : smag);
			end
		endcase
		case ($urandom_range(0, 9))
			0: r.pid_drive = '0;
			1, 2: r.pid_drive = 24'($urandom);
			3: r.pid_drive = to_q(last_neg[m] ? longint'($urandom_range(1, 5000))
				: -longint'($urandom_range(1, 5000)));
			default: r.pid_drive = to_q(last_neg[m] ? -longint'($urandom_range(0, 20000))
				: longint'($urandom_range(0, 20000)));
		endcase
		return r;
	endfunction

	// Response side: draws a stall before each response, takes it, and
	// compares it with the oldest expectation. A long hold-off requested by
	// the stimulus is counted out here.
	initial begin : receive_proc
		int   stall;
		rsp_t want;
		rsp_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = recv_idle_on ? $urandom_range(0, 12) : 0;
			if (long_hold > 0) begin
				stall     = long_hold;
				long_hold = 0;
			end
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do
				@(posedge clk);
			while (!rsp_valid);
			if (pending_drive.size() == 0) begin
				$error("response with no request outstanding: motor_id %0d drive_out %0d",
					rsp.motor_id, $signed(rsp.drive_out));
				error_count++;
			end else begin
				want = pending_drive.pop_front();
				if (rsp.motor_id !== want.motor_id) begin
					$error("motor_id: expected %0d, got %0d", want.motor_id, rsp.motor_id);
					error_count++;
				end
				if (rsp.drive_out !== want.drive_out) begin
					$error("drive_out: expected %0d, got %0d",
						$signed(want.drive_out), $signed(rsp.drive_out));
					error_count++;
				end
			end
		end
	end

	// Watchdog: ends the run if neither channel moves for too long.
	initial begin : watchdog_proc
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("motor_drive_compensation: mismatch");
				$finish;
			end
		end
	end

	// Main stimulus: reset, the directed table, then the random phases.
	initial begin : stimulus_proc
		req_t r;
		arst_n         <= 1'b0;
		req_valid      <= 1'b0;
		req            <= '0;
		cfg_we         <= 1'b0;
		cfg_index      <= '0;
		cfg_wdata      <= '0;
		error_count    = 0;
		long_hold      = 0;
		send_idle_on   = 1'b1;
		recv_idle_on   = 1'b1;
		cur_now        = '0;
		last_neg       = '{1'b0, 1'b0};
		// Register and state values the block holds after reset.
		set_deadband   = 23'd1280;
		set_limit      = 23'h7FFFFF;
		set_gain       = 32'h1000_1000;
		set_min        = '0;
		set_boost      = '0;
		set_boost_time = '0;
		motor_prev_target = '{0, 0};
		motor_boost_end   = '{32'd0, 32'd0};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Register writes in the table wait for the block to go idle first.
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (DIRECTED[i].kind == ROW_CFG) begin
				drain_requests();
				load_reg(DIRECTED[i].idx, DIRECTED[i].data);
			end else begin
				r.motor_sel      = DIRECTED[i].motor;
				r.speed_cmd      = DIRECTED[i].target;
				r.measured_speed = DIRECTED[i].meas;
				r.pid_drive      = DIRECTED[i].pid;
				r.now_ms         = DIRECTED[i].now;
				send_req(r, DIRECTED[i].chk, DIRECTED[i].drive);
			end
		end

		// Each phase starts from an idle block with fresh settings. Phase 3
		// makes the receiver hold off for a long stretch while requests keep
		// coming, so the pipeline fills and back-pressures its input. Phases
		// 4 and 6 run without idling on one or both sides.
		for (int p = 0; p < PHASES; p++) begin
			drain_requests();
			load_phase_settings(p);
			send_idle_on = (p != 4) && (p != 6);
			recv_idle_on = (p != 4);
			cur_now      = (p % 3 == 0) ? 32'hFFFFFE00 : $urandom;
			if (p == 3)
				long_hold = LONG_HOLD;
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_req(next_sample(), 1'b0, '0);
		end

		drain_requests();
		repeat (10) @(posedge clk);
		if (error_count == 0 && pending_drive.size() == 0)
			$display("motor_drive_compensation: match");
		else
			$display("motor_drive_compensation: mismatch");
		$finish;
	end

endmodule

// File: files.f
src/mdc_pkg.sv
src/mdc_cfg.sv
src/mdc_state_mem.sv
src/motor_drive_compensation.sv
verif/tb_motor_drive_compensation.sv
